// ===== hw/rtl/fwr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the queue with reverse-first-k operation.
// Used by the controller, the datapath and the top level.
package fwr_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 16;

	typedef logic signed [31:0] word_t;
	typedef logic [1:0]         func_t;
	typedef logic [1:0]         status_code_t;
	typedef logic [7:0]         rev_count_t;
	typedef logic [4:0]         entry_count_t;

	localparam func_t FUNC_PUSH    = 2'd0;
	localparam func_t FUNC_POP     = 2'd1;
	localparam func_t FUNC_REVERSE = 2'd2;

	localparam status_code_t ST_OK        = 2'd0;
	localparam status_code_t ST_UNDERFLOW = 2'd1;
	localparam status_code_t ST_OVERFLOW  = 2'd2;
	localparam status_code_t ST_INVALID   = 2'd3;

	localparam word_t EMPTY_WORD = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_TEST,
		S_SWAP_RD,
		S_SWAP_WR_A,
		S_SWAP_WR_B,
		S_FETCH,
		S_LOAD
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic exec;
		logic swap_rd;
		logic swap_wr_a;
		logic swap_wr_b;
		logic fetch;
		logic load;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic swap_more;
	} dp_stat_t;

endpackage

// ===== hw/rtl/fwr_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module fwr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== hw/rtl/fwr_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the queue: request execution, swap loop for reverse, result fetch.
// Depends on fwr_pkg.
module fwr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output fwr_pkg::dp_cmd_t  cmd,
	input  fwr_pkg::dp_stat_t stat
);
	import fwr_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_TEST;
			end
			S_TEST: begin
				state_d = stat.swap_more ? S_SWAP_RD : S_FETCH;
			end
			S_SWAP_RD: begin
				cmd.swap_rd = 1'b1;
				state_d     = S_SWAP_WR_A;
			end
			S_SWAP_WR_A: begin
				cmd.swap_wr_a = 1'b1;
				state_d       = S_SWAP_WR_B;
			end
			S_SWAP_WR_B: begin
				cmd.swap_wr_b = 1'b1;
				state_d       = S_TEST;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/fwr_dp.sv =====
`timescale 1ns / 1ps
// Datapath: ring store, head and count, swap pointers and result registers.
// Depends on fwr_pkg and fwr_ram.
module fwr_dp #(
	parameter int QUEUE_DEPTH = fwr_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fwr_pkg::dp_cmd_t      cmd,
	output fwr_pkg::dp_stat_t     stat,
	input  fwr_pkg::func_t        func,
	input  fwr_pkg::word_t        push_value,
	input  fwr_pkg::rev_count_t   reverse_count,
	output logic                  done,
	output fwr_pkg::word_t        front_value,
	output fwr_pkg::word_t        back_value,
	output logic                  is_empty,
	output fwr_pkg::entry_count_t entry_count,
	output fwr_pkg::status_code_t status
);
	import fwr_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MW = (CW > 8) ? CW : 8;
	localparam logic [AW:0]   DEPTH_A = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] lo_q, hi_q;
	func_t         func_q;
	word_t         value_q;
	rev_count_t    k_q;
	word_t         tmp_q;
	status_code_t  status_q;

	logic          full, empty, rev_ok;
	logic [CW-1:0] rev_len;
	status_code_t  exec_status;

	logic          we;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	word_t         wdata, rdata_a, rdata_b;

	// Ring position of the entry that sits off places behind the front.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
		input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, head} + {1'b0, off};
		if (s >= DEPTH_A) begin
			s = s - DEPTH_A;
		end
		return s[AW-1:0];
	endfunction

	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign rev_ok  = (k_q != '0) && !empty;
	assign rev_len = (MW'(k_q) < MW'(count_q)) ? CW'(k_q) : count_q;

	always_comb begin
		unique case (func_q)
			FUNC_PUSH:    exec_status = full ? ST_OVERFLOW : ST_OK;
			FUNC_POP:     exec_status = empty ? ST_UNDERFLOW : ST_OK;
			FUNC_REVERSE: exec_status = rev_ok ? ST_OK : ST_INVALID;
			default:      exec_status = ST_INVALID;
		endcase
	end

	assign stat.swap_more = (lo_q < hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			done    <= 1'b0;
		end else begin
			done <= cmd.load;
			if (cmd.exec) begin
				lo_q <= '0;
				hi_q <= '0;
				if (func_q == FUNC_PUSH && !full) begin
					count_q <= count_q + 1'b1;
				end
				if (func_q == FUNC_POP && !empty) begin
					head_q  <= slot(head_q, AW'(1));
					count_q <= count_q - 1'b1;
				end
				if (func_q == FUNC_REVERSE && rev_ok) begin
					hi_q <= AW'(rev_len - 1'b1);
				end
			end
			// advance the swap window inward
			if (cmd.swap_wr_b) begin
				lo_q <= lo_q + 1'b1;
				hi_q <= hi_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= func;
			value_q <= push_value;
			k_q     <= reverse_count;
		end
		if (cmd.exec) begin
			status_q <= exec_status;
		end
		if (cmd.swap_wr_a) begin
			tmp_q <= rdata_a;
		end
		if (cmd.load) begin
			front_value <= empty ? EMPTY_WORD : rdata_a;
			back_value  <= empty ? EMPTY_WORD : rdata_b;
			is_empty    <= empty;
			entry_count <= 5'(count_q);
			status      <= status_q;
		end
	end

	assign raddr_a = cmd.fetch ? head_q : slot(head_q, lo_q);
	assign raddr_b = cmd.fetch ? slot(head_q, AW'(count_q - 1'b1)) : slot(head_q, hi_q);

	always_comb begin
		we    = 1'b0;
		waddr = slot(head_q, lo_q);
		wdata = rdata_b;
		if (cmd.exec) begin
			we    = (func_q == FUNC_PUSH) && !full;
			waddr = slot(head_q, AW'(count_q));
			wdata = value_q;
		end else if (cmd.swap_wr_a) begin
			we = 1'b1;
		end else if (cmd.swap_wr_b) begin
			we    = 1'b1;
			waddr = slot(head_q, hi_q);
			wdata = tmp_q;
		end
	end

	fwr_ram #(
		.WIDTH(32),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

endmodule

// ===== hw/rtl/fifo_with_reverse_first_k.sv =====
`timescale 1ns / 1ps
// Bounded queue of signed 32-bit words with push, pop and reverse-first-k requests.
// Request channel: drive func, push_value and reverse_count with start high; the
// request is taken at a rising edge where start is high and busy is low.
// Result channel: done pulses for one cycle with front_value, back_value, is_empty,
// entry_count and status. The receiver cannot stall; a result must be taken in
// the cycle that done is high.
// Sequence: each request passes the exec, test, fetch and load states in turn. A valid
// reverse of m = min(k, count) entries runs floor(m/2) swaps between test and fetch,
// one read and two writes on the single write port of the store for each swap.
// busy drops in the cycle done is high, so the next request can be taken there;
// no new request is taken while one is in flight.
// Reset: head and count go to zero, the queue is empty and the block is idle.
// The store itself is not cleared; only written entries ever reach the outputs.
// Depends on fwr_pkg, fwr_ctrl, fwr_dp and fwr_ram.
module fifo_with_reverse_first_k #(
	parameter int QUEUE_DEPTH = fwr_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  fwr_pkg::func_t        func,
	input  fwr_pkg::word_t        push_value,
	input  fwr_pkg::rev_count_t   reverse_count,
	output logic                  done,
	output fwr_pkg::word_t        front_value,
	output fwr_pkg::word_t        back_value,
	output logic                  is_empty,
	output fwr_pkg::entry_count_t entry_count,
	output fwr_pkg::status_code_t status
);
	import fwr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fwr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.stat  (stat)
	);

	fwr_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.push_value   (push_value),
		.reverse_count(reverse_count),
		.done         (done),
		.front_value  (front_value),
		.back_value   (back_value),
		.is_empty     (is_empty),
		.entry_count  (entry_count),
		.status       (status)
	);

	// A result only follows a cycle in which a request was in flight.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

	// A taken request keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after taking a request");

	// At most one datapath command per cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.exec, cmd.swap_rd, cmd.swap_wr_a, cmd.swap_wr_b,
			cmd.fetch, cmd.load}))
		else $error("overlapping datapath commands");

endmodule
